>>> sv/rrip_replacement_with_stream_bypass_defines.svh
// ----------------------------------------------------------------------------
// RRIP replacement assertion macros
// Concurrent assertion helpers shared by the replacement block.
// ----------------------------------------------------------------------------
`ifndef RRIP_REPLACEMENT_WITH_STREAM_BYPASS_DEFINES_SVH
`define RRIP_REPLACEMENT_WITH_STREAM_BYPASS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define RRIP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled during reset.
`define RRIP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RRIP_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define RRIP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> sv/rrip_pkg.sv
// ----------------------------------------------------------------------------
// RRIP replacement package
// Sizes, row layout, request and response types shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package rrip_pkg;

   localparam int NUM_SETS   = 2048;
   localparam int NUM_WAYS   = 16;
   localparam int STREAM_LEN = 4;

   localparam int SET_BITS   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int SET_FIELD  = 11;
   localparam int WAY_FIELD  = 4;
   localparam int ADDR_FIELD = 16;
   localparam int PC_FIELD   = 18;
   localparam int SIG_WIDTH  = 5;
   localparam int STREAK_BITS = 3;

   localparam logic [1:0] RRPV_TOP    = 2'd3;
   localparam logic [1:0] OUTCOME_TOP = 2'd3;
   localparam logic [1:0] OUTCOME_RST = 2'd1;
   localparam logic [1:0] OUTCOME_HOT = 2'd2;
   localparam logic [STREAK_BITS-1:0] STREAK_LEN = STREAK_BITS'(STREAM_LEN);

   localparam logic REQ_QUERY  = 1'b0;
   localparam logic REQ_UPDATE = 1'b1;

   typedef struct packed {
      logic [1:0]           rrpv;
      logic [1:0]           outcome;
      logic [SIG_WIDTH-1:0] sig;
   } line_type;

   typedef struct packed {
      line_type [NUM_WAYS-1:0]  line;
      logic [ADDR_FIELD-1:0]    last_addr;
      logic [ADDR_FIELD-1:0]    stride_delta;
      logic [STREAK_BITS-1:0]   streak;
   } row_type;

   localparam int ROW_BITS = $bits(row_type);

   typedef struct packed {
      logic                  kind;
      logic [SET_FIELD-1:0]  set_index;
      logic [WAY_FIELD-1:0]  way_index;
      logic [ADDR_FIELD-1:0] line_addr;
      logic [PC_FIELD-1:0]   pc_bits;
      logic                  hit_flag;
      logic                  victim_present;
   } req_item_type;

   typedef struct packed {
      logic [WAY_FIELD-1:0] victim_way;
      logic                 streaming_seen;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   function automatic row_type reset_row();
      row_type r;
      for (int w = 0; w < NUM_WAYS; w++) begin
         r.line[w].rrpv    = RRPV_TOP;
         r.line[w].outcome = OUTCOME_RST;
         r.line[w].sig     = '0;
      end
      r.last_addr    = '0;
      r.stride_delta = '0;
      r.streak       = '0;
      return r;
   endfunction

   function automatic logic [SIG_WIDTH-1:0] sig_hash(input logic [PC_FIELD-1:0] pc);
      return pc[4:0] ^ pc[11:7] ^ pc[17:13];
   endfunction

endpackage

`default_nettype wire

>>> sv/rrip_row_ram.sv
// ----------------------------------------------------------------------------
// RRIP row RAM
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rrip_row_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/rrip_update.sv
// ----------------------------------------------------------------------------
// RRIP row update
// Computes the new set row and the response for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module rrip_update (
   input  wire rrip_pkg::req_item_type req,
   input  wire rrip_pkg::row_type      row_in,
   output rrip_pkg::row_type           row_out,
   output rrip_pkg::rsp_item_type      rsp
);

   import rrip_pkg::*;

   logic                   any3;
   logic                   any2;
   logic                   any1;
   logic [1:0]             age_add;
   logic [ADDR_FIELD-1:0]  delta;
   logic                   stride_match;
   logic [STREAK_BITS-1:0] streak_next;
   logic                   strm;
   logic [SIG_WIDTH-1:0]   sig;

   always_comb begin
      any3 = 1'b0;
      any2 = 1'b0;
      any1 = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         any3 = any3 | (row_in.line[w].rrpv == 2'd3);
         any2 = any2 | (row_in.line[w].rrpv == 2'd2);
         any1 = any1 | (row_in.line[w].rrpv == 2'd1);
      end
      if (any3) begin
         age_add = 2'd0;
      end else if (any2) begin
         age_add = 2'd1;
      end else if (any1) begin
         age_add = 2'd2;
      end else begin
         age_add = 2'd3;
      end
   end

   // Stride detector over the low address bits.
   always_comb begin
      delta        = req.line_addr - row_in.last_addr;
      stride_match = (row_in.streak != '0) && (delta == row_in.stride_delta) &&
                     (delta != '0);
      if (stride_match) begin
         streak_next = (row_in.streak < STREAK_LEN) ?
                       row_in.streak + STREAK_BITS'(1) : row_in.streak;
      end else begin
         streak_next = STREAK_BITS'(1);
      end
      strm = stride_match && (streak_next >= STREAK_LEN);
      sig  = sig_hash(req.pc_bits);
   end

   always_comb begin
      row_out = row_in;
      rsp     = '0;
      case (req.kind)
         REQ_QUERY: begin
            for (int w = 0; w < NUM_WAYS; w++) begin
               row_out.line[w].rrpv = row_in.line[w].rrpv + age_add;
            end
            for (int w = NUM_WAYS - 1; w >= 0; w--) begin
               if (row_out.line[w].rrpv == RRPV_TOP) begin
                  rsp.victim_way = WAY_FIELD'(w);
               end
            end
         end
         REQ_UPDATE: begin
            row_out.last_addr = req.line_addr;
            row_out.streak    = streak_next;
            if (!stride_match) begin
               row_out.stride_delta = delta;
            end
            for (int w = 0; w < NUM_WAYS; w++) begin
               if (int'(req.way_index) == w) begin
                  if (req.hit_flag) begin
                     row_out.line[w].rrpv = 2'd0;
                     if (row_in.line[w].outcome < OUTCOME_TOP) begin
                        row_out.line[w].outcome = row_in.line[w].outcome + 2'd1;
                     end
                  end else if (strm) begin
                     row_out.line[w].rrpv = RRPV_TOP;
                  end else begin
                     row_out.line[w].rrpv =
                        (row_in.line[w].outcome >= OUTCOME_HOT) ? 2'd0 : RRPV_TOP;
                     row_out.line[w].sig = sig;
                  end
               end
            end
            // A miss that evicted a line decays every outcome counter in the set.
            if (!req.hit_flag && req.victim_present) begin
               for (int w = 0; w < NUM_WAYS; w++) begin
                  if (row_out.line[w].outcome != 2'd0) begin
                     row_out.line[w].outcome = row_out.line[w].outcome - 2'd1;
                  end
               end
            end
            rsp.streaming_seen = strm;
         end
         default: begin
            row_out = row_in;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> sv/rrip_replacement_with_stream_bypass.sv
// ----------------------------------------------------------------------------
// RRIP replacement with streaming bypass
// SRRIP victim selection and update with a per-set stride detector.
// ----------------------------------------------------------------------------
// The request channel (req_*) carries victim queries and access updates for
// one cache set each. Every request yields exactly one response transfer on
// the rsp_* channel: the victim way for a query, the streaming flag for an
// update.
//
// All per-line and per-set state lives in one row of a synchronous RAM per
// set. A request is accepted and its set row is read in the accept cycle; in
// the execute state, once the output register is free, the row is modified
// and written back while the response is loaded into the output register.
// Because of the read-then-write on the single row RAM, the next request may
// be accepted in the cycle after the write-back.
//
// After reset the block clears the RAM to its reset row, one set per cycle,
// covering all 2048 sets; req_ready stays low during this pass.
//
// The output register lets a new request be accepted while a response waits.
// If the receiver holds rsp_ready low, the next request stays in its execute
// cycle, without writing back, until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rrip_replacement_with_stream_bypass_defines.svh"

module rrip_replacement_with_stream_bypass (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_type,
   input  wire logic [rrip_pkg::SET_FIELD-1:0]  req_set_index,
   input  wire logic [rrip_pkg::WAY_FIELD-1:0]  req_way_index,
   input  wire logic [rrip_pkg::ADDR_FIELD-1:0] req_line_addr,
   input  wire logic [rrip_pkg::PC_FIELD-1:0]   req_pc_bits,
   input  wire logic                            req_hit_flag,
   input  wire logic                            req_victim_present,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [rrip_pkg::WAY_FIELD-1:0]  rsp_victim_way,
   output logic                                 rsp_streaming_seen
);

   import rrip_pkg::*;

   state_type             state_ff, state_in;
   logic [SET_BITS-1:0]   clear_addr_ff, clear_addr_in;
   req_item_type          req_ff, req_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_ff, rsp_in;

   logic                  accept;
   logic                  out_free;
   logic                  exec_go;
   logic                  clearing;
   logic                  last_clear;

   logic                  wr_en;
   logic [SET_BITS-1:0]   wr_addr;
   logic [ROW_BITS-1:0]   wr_data;
   logic [ROW_BITS-1:0]   rd_data;
   row_type               row_new;
   rsp_item_type          rsp_new;

   // Incoming transfer collected as one item.
   req_item_type          req_port;

   assign req_port.kind           = req_type;
   assign req_port.set_index      = req_set_index;
   assign req_port.way_index      = req_way_index;
   assign req_port.line_addr      = req_line_addr;
   assign req_port.pc_bits        = req_pc_bits;
   assign req_port.hit_flag       = req_hit_flag;
   assign req_port.victim_present = req_victim_present;

   assign clearing   = (state_ff == ST_CLEAR);
   assign last_clear = (clear_addr_ff == SET_BITS'(NUM_SETS - 1));
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign exec_go    = (state_ff == ST_EXEC) && out_free;

   // The row is read at the accept edge and written back when the item
   // executes; the clearing pass owns the write port until it finishes.
   assign wr_en   = clearing || exec_go;
   assign wr_addr = clearing ? clear_addr_ff : req_ff.set_index[SET_BITS-1:0];
   assign wr_data = clearing ? ROW_BITS'(reset_row()) : ROW_BITS'(row_new);

   rrip_row_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (NUM_SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (req_set_index[SET_BITS-1:0]),
      .rd_data (rd_data)
   );

   rrip_update u_update (
      .req     (req_ff),
      .row_in  (row_type'(rd_data)),
      .row_out (row_new),
      .rsp     (rsp_new)
   );

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + SET_BITS'(1);
            if (last_clear) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_port;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               rsp_in       = rsp_new;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_victim_way     = rsp_ff.victim_way;
   assign rsp_streaming_seen = rsp_ff.streaming_seen;

   // Only one request is in flight: the cycle after an accept is never ready.
   `RRIP_ASSERT_NEXT(a_one_in_flight, clock, reset, accept, !req_ready, "second request accepted while one is in flight")

   // Every write-back of an executed item loads the response register.
   `RRIP_ASSERT_NEXT(a_writeback_rsp, clock, reset, exec_go, rsp_valid, "write-back without a response")

   // A query never reports streaming and an update never reports a victim.
   `RRIP_ASSERT_SAME(a_rsp_fields, clock, reset, rsp_valid, (rsp_victim_way == '0) || !rsp_streaming_seen, "response mixes query and update fields")

   // No request is taken while the clearing pass still owns the RAM.
   `RRIP_ASSERT_SAME(a_no_accept_clear, clock, reset, clearing, !accept, "request accepted during the clearing pass")

endmodule

`default_nettype wire

>>> tb/rrip_check_pkg.sv
// ----------------------------------------------------------------------------
// RRIP replacement scoreboard
// Keeps a private copy of the per-line and per-set replacement state, works
// out the expected response for every accepted request and checks responses
// in order against those expectations.
// ----------------------------------------------------------------------------
package rrip_check_pkg;

   import rrip_pkg::*;

   class rrip_scoreboard;

      logic [1:0]             rrpv_tab    [NUM_SETS][NUM_WAYS];
      logic [1:0]             outcome_tab [NUM_SETS][NUM_WAYS];
      logic [SIG_WIDTH-1:0]   sig_tab     [NUM_SETS][NUM_WAYS];
      logic [ADDR_FIELD-1:0]  prev_addr   [NUM_SETS];
      logic [ADDR_FIELD-1:0]  prev_delta  [NUM_SETS];
      logic [STREAK_BITS-1:0] streak      [NUM_SETS];
      rsp_item_type           expected_q[$];
      int                     mismatches;

      function new();
         for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
               rrpv_tab[s][w]    = RRPV_TOP;
               outcome_tab[s][w] = 2'd1;
               sig_tab[s][w]     = '0;
            end
            prev_addr[s]  = '0;
            prev_delta[s] = '0;
            streak[s]     = '0;
         end
         mismatches = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("mismatch %0d at %0t: %s", mismatches, $realtime, what);
      endtask

      // Lowest way at the top RRPV, after aging the whole set if none is there.
      function int unsigned age_and_pick(int unsigned s);
         logic [1:0]  top;
         int unsigned found;
         top   = '0;
         found = 0;
         for (int w = 0; w < NUM_WAYS; w++)
            if (rrpv_tab[s][w] > top) top = rrpv_tab[s][w];
         if (top < RRPV_TOP)
            for (int w = 0; w < NUM_WAYS; w++)
               rrpv_tab[s][w] = rrpv_tab[s][w] + (RRPV_TOP - top);
         for (int w = NUM_WAYS - 1; w >= 0; w--)
            if (rrpv_tab[s][w] == RRPV_TOP) found = w;
         return found;
      endfunction

      // Stride detector; returns 1 when the access belongs to a stream.
      function logic track_stride(int unsigned s, logic [ADDR_FIELD-1:0] addr);
         logic [ADDR_FIELD-1:0] delta;
         logic                  streaming;
         delta     = addr - prev_addr[s];
         streaming = 1'b0;
         if (streak[s] != 0 && delta == prev_delta[s] && delta != 0) begin
            if (streak[s] < STREAM_LEN) streak[s] = streak[s] + 1'b1;
            if (streak[s] >= STREAM_LEN) streaming = 1'b1;
         end else begin
            prev_delta[s] = delta;
            streak[s]     = 1;
         end
         prev_addr[s] = addr;
         return streaming;
      endfunction

      function void note_request(req_item_type req);
         int unsigned  s;
         int unsigned  w;
         logic         streaming;
         rsp_item_type want;
         s    = req.set_index % NUM_SETS;
         w    = req.way_index;
         want = '0;
         if (req.kind == REQ_QUERY) begin
            want.victim_way = WAY_FIELD'(age_and_pick(s));
         end else begin
            streaming = track_stride(s, req.line_addr);
            if (w < NUM_WAYS) begin
               if (req.hit_flag) begin
                  rrpv_tab[s][w] = '0;
                  if (outcome_tab[s][w] < OUTCOME_TOP)
                     outcome_tab[s][w] = outcome_tab[s][w] + 1'b1;
               end else if (streaming) begin
                  rrpv_tab[s][w] = RRPV_TOP;
               end else begin
                  rrpv_tab[s][w] = (outcome_tab[s][w] >= 2) ? 2'd0 : RRPV_TOP;
                  sig_tab[s][w]  = SIG_WIDTH'(req.pc_bits ^ (req.pc_bits >> 7)
                                              ^ (req.pc_bits >> 13));
               end
            end
            // An eviction on a miss cools down every line of the set.
            if (!req.hit_flag && req.victim_present)
               for (int v = 0; v < NUM_WAYS; v++)
                  if (outcome_tab[s][v] > 0) outcome_tab[s][v] = outcome_tab[s][v] - 1'b1;
            want.streaming_seen = streaming;
         end
         expected_q.push_back(want);
      endfunction

      task check_response(logic [WAY_FIELD-1:0] way, logic streaming);
         rsp_item_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("response way=%0d stream=%0b with nothing outstanding",
                                      way, streaming));
            return;
         end
         want = expected_q.pop_front();
         if (way !== want.victim_way)
            report_mismatch($sformatf("victim_way %0d, expected %0d", way, want.victim_way));
         if (streaming !== want.streaming_seen)
            report_mismatch($sformatf("streaming_seen %0b, expected %0b",
                                      streaming, want.streaming_seen));
      endtask

   endclass

endpackage

>>> tb/rrip_replacement_with_stream_bypass_test.sv
// ----------------------------------------------------------------------------
// RRIP replacement with streaming bypass testbench
// Drives victim queries and access updates through the request channel and
// checks every response transfer against a scoreboard that tracks the whole
// replacement state, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module rrip_replacement_with_stream_bypass_test;

   import rrip_pkg::*;
   import rrip_check_pkg::*;

   // Roughly 1350 requests in all: the directed list plus four random phases.
   localparam int PHASE_ITEMS    = 331;
   localparam int HOT_SETS       = 4;
   // The quiet-cycle limit sits well above both the clearing pass after reset
   // and the long receiver hold-off.
   localparam int WATCHDOG_LIMIT = 8000;
   localparam int HOLD_AFTER     = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 20;

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_ready;
   logic                  req_type           = REQ_QUERY;
   logic [SET_FIELD-1:0]  req_set_index      = '0;
   logic [WAY_FIELD-1:0]  req_way_index      = '0;
   logic [ADDR_FIELD-1:0] req_line_addr      = '0;
   logic [PC_FIELD-1:0]   req_pc_bits        = '0;
   logic                  req_hit_flag       = 1'b0;
   logic                  req_victim_present = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready          = 1'b0;
   logic [WAY_FIELD-1:0]  rsp_victim_way;
   logic                  rsp_streaming_seen;

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // A few sets take most of the traffic so that streams build up, lines
   // heat up and sets age. Each keeps its own stride generator.
   int unsigned           hot_set     [HOT_SETS];
   logic [ADDR_FIELD-1:0] next_addr   [HOT_SETS];
   logic [ADDR_FIELD-1:0] stride      [HOT_SETS];

   rrip_scoreboard sb;

   rrip_replacement_with_stream_bypass uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_set_index      (req_set_index),
      .req_way_index      (req_way_index),
      .req_line_addr      (req_line_addr),
      .req_pc_bits        (req_pc_bits),
      .req_hit_flag       (req_hit_flag),
      .req_victim_present (req_victim_present),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_victim_way     (rsp_victim_way),
      .rsp_streaming_seen (rsp_streaming_seen)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic req_item_type make_item(logic kind, int unsigned set, int unsigned way,
                                              logic [ADDR_FIELD-1:0] addr,
                                              logic [PC_FIELD-1:0] pc, logic hit, logic vic);
      req_item_type r;
      r.kind           = kind;
      r.set_index      = SET_FIELD'(set);
      r.way_index      = WAY_FIELD'(way);
      r.line_addr      = addr;
      r.pc_bits        = pc;
      r.hit_flag       = hit;
      r.victim_present = vic;
      return r;
   endfunction

   // Offers one request and returns at the edge where it is transferred. The
   // valid line is lowered only when an idle gap is taken, so it is never
   // dropped and raised again within one edge.
   task send_request(req_item_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= item.kind;
      req_set_index      <= item.set_index;
      req_way_index      <= item.way_index;
      req_line_addr      <= item.line_addr;
      req_pc_bits        <= item.pc_bits;
      req_hit_flag       <= item.hit_flag;
      req_victim_present <= item.victim_present;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
   endtask

   // Stops offering until every outstanding response has been transferred.
   task wait_for_responses();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Next address of hot set h: mostly the next stride step, sometimes a
   // repeat (zero delta), a new stride or a jump that breaks the stream.
   function automatic logic [ADDR_FIELD-1:0] stream_addr(int unsigned h);
      int unsigned           pick;
      logic [ADDR_FIELD-1:0] addr;
      pick = $urandom_range(99);
      if (pick < 4) stride[h] = ADDR_FIELD'($urandom_range(64, 1));
      else if (pick < 8) stride[h] = ADDR_FIELD'($urandom);
      if (pick < 78) begin
         addr         = next_addr[h];
         next_addr[h] = next_addr[h] + stride[h];
      end else if (pick < 86) begin
         addr = next_addr[h] - stride[h];
      end else begin
         addr         = ADDR_FIELD'($urandom);
         next_addr[h] = addr + stride[h];
      end
      return addr;
   endfunction

   task run_random(int count);
      int           made;
      int unsigned  h;
      req_item_type r;
      made = 0;
      while (made < count) begin
         h = $urandom_range(HOT_SETS - 1);
         if ($urandom_range(99) < 5) begin
            // Warm every way of one set with hits, then ask for a victim so
            // that the set has to age.
            for (int w = 0; w < NUM_WAYS; w++)
               send_request(make_item(REQ_UPDATE, hot_set[h], w, stream_addr(h),
                                      PC_FIELD'($urandom), 1'b1, 1'($urandom)));
            send_request(make_item(REQ_QUERY, hot_set[h], $urandom_range(15),
                                   ADDR_FIELD'($urandom), PC_FIELD'($urandom),
                                   1'($urandom), 1'($urandom)));
            made += NUM_WAYS + 1;
         end else begin
            r = make_item(($urandom_range(99) < 30) ? REQ_QUERY : REQ_UPDATE, hot_set[h],
                          $urandom_range(15), ADDR_FIELD'($urandom), PC_FIELD'($urandom),
                          $urandom_range(99) < 55, $urandom_range(99) < 35);
            if ($urandom_range(99) < 15) r.set_index = SET_FIELD'($urandom);
            else if (r.kind == REQ_UPDATE) r.line_addr = stream_addr(h);
            send_request(r);
            made++;
         end
      end
   endtask

   task run_directed();
      // Fresh sets answer way 0; fields other than the set do not matter.
      send_request(make_item(REQ_QUERY, 0, 0, '0, '0, 1'b0, 1'b0));
      send_request(make_item(REQ_QUERY, 2047, 15, '1, '1, 1'b1, 1'b1));
      // Hits on every way of set 3. All addresses but the last form a stride of
      // 64, so the later of those hits also report a stream; the last hit carries
      // a victim flag, which a hit ignores.
      for (int w = 0; w < NUM_WAYS; w++)
         send_request(make_item(REQ_UPDATE, 3, w, (w == 15) ? 16'hFFFF : ADDR_FIELD'(w * 64),
                                (w == 15) ? '1 : PC_FIELD'(w), 1'b1, w == 15));
      // No way is left at the top RRPV, so the query ages the whole set.
      send_request(make_item(REQ_QUERY, 3, 0, '0, '0, 1'b0, 1'b0));
      // Miss on a hot line fills near; a miss with a victim decays the set;
      // the next miss then finds a cold line and fills far.
      send_request(make_item(REQ_UPDATE, 3, 0, 16'h1000, 18'h2AAAA, 1'b0, 1'b0));
      send_request(make_item(REQ_UPDATE, 3, 1, 16'h2000, 18'h15555, 1'b0, 1'b1));
      send_request(make_item(REQ_UPDATE, 3, 2, 16'h3000, 18'h3FFFF, 1'b0, 1'b0));
      // A stride of 8 that wraps through zero; misses inside the stream fill
      // far, and a repeated address (zero delta) ends the stream.
      send_request(make_item(REQ_UPDATE, 9, 4, 16'hFFF8, 18'h00001, 1'b0, 1'b0));
      send_request(make_item(REQ_UPDATE, 9, 4, 16'h0000, 18'h00002, 1'b0, 1'b0));
      send_request(make_item(REQ_UPDATE, 9, 5, 16'h0008, 18'h00004, 1'b0, 1'b0));
      send_request(make_item(REQ_UPDATE, 9, 6, 16'h0010, 18'h00008, 1'b0, 1'b0));
      send_request(make_item(REQ_UPDATE, 9, 7, 16'h0018, 18'h00010, 1'b0, 1'b1));
      send_request(make_item(REQ_UPDATE, 9, 8, 16'h0018, 18'h00020, 1'b0, 1'b0));
   endtask

   // Main sequence: reset, directed requests, then four random phases with
   // different idle and stall patterns. Between phases the sender waits for
   // every outstanding response.
   initial begin
      sb           = new();
      hot_set[0]   = 0;
      hot_set[1]   = NUM_SETS - 1;
      hot_set[2]   = $urandom_range(NUM_SETS - 2, 1);
      hot_set[3]   = $urandom_range(NUM_SETS - 2, 1);
      for (int h = 0; h < HOT_SETS; h++) begin
         next_addr[h] = ADDR_FIELD'($urandom);
         stride[h]    = ADDR_FIELD'($urandom_range(64, 1));
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      wait_for_responses();
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 63 : (phase == 3) ? 35 : 0;
         rsp_stall_pct = (phase == 2) ? 63 : (phase == 3) ? 35 : 0;
         run_random(PHASE_ITEMS);
         wait_for_responses();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending()));
      if (sb.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Receiver: checks each response transfer and drives rsp_ready. Once,
   // early in the first random phase, it holds off for a long stretch while
   // the sender keeps offering, so the block backs up and stalls its input.
   initial begin
      int checked;
      int hold_left;
      bit held;
      checked   = 0;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            sb.check_response(rsp_victim_way, rsp_streaming_seen);
            checked++;
         end
         if (!held && checked == HOLD_AFTER) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog: ends the run when no transfer happens on either channel for
   // too long.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

endmodule

>>> files.f
+incdir+sv
sv/rrip_pkg.sv
sv/rrip_row_ram.sv
sv/rrip_update.sv
sv/rrip_replacement_with_stream_bypass.sv
tb/rrip_check_pkg.sv
tb/rrip_replacement_with_stream_bypass_test.sv
